/* rtl/mswc_pkg.sv */
`timescale 1ns / 1ps

package mswc_pkg;

    localparam int IDX_W = 7;
    localparam int VAL_W = 32;
    localparam int CNT_W = 9;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_MERGE
    } t_phase;

    typedef struct packed {
        t_idx   lo;
        t_idx   hi;
        t_phase ph;
    } t_frame;

    typedef struct packed {
        logic go;
        t_idx lo;
        t_idx mid;
        t_idx hi;
    } t_merge_cmd;

    typedef enum logic [1:0] {
        TS_LOAD,
        TS_SORT,
        TS_EMIT
    } t_top_state;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_STEP,
        SQ_WAIT
    } t_seq_state;

    typedef enum logic [1:0] {
        MG_IDLE,
        MG_MERGE,
        MG_COPY
    } t_merge_state;

endpackage

/* rtl/mswc_merge.sv */
`timescale 1ns / 1ps

module mswc_merge #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mswc_pkg::t_merge_cmd        i_cmd,
    input  logic                        i_clr,
    input  logic                        i_wr_en,
    input  mswc_pkg::t_idx              i_wr_addr,
    input  logic [mswc_pkg::VAL_W-1:0]  i_wr_data,
    input  mswc_pkg::t_idx              i_rd_addr,
    output logic [mswc_pkg::VAL_W-1:0]  o_rd_data,
    output logic                        o_done,
    output logic [mswc_pkg::CNT_W-1:0]  o_cmp_total,
    output logic [mswc_pkg::CNT_W-1:0]  o_mov_total
);
    import mswc_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic [VAL_W-1:0] r_store   [MAX_ELEMENTS];
    logic [VAL_W-1:0] r_scratch [MAX_ELEMENTS];

    t_merge_state     r_state, n_state;
    t_idx             r_a, n_a, r_b, n_b, r_k, n_k;
    t_idx             r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [VAL_W-1:0] r_rd_a, r_rd_b, r_sc;
    logic [CNT_W-1:0] r_cmp, n_cmp, r_mov, n_mov;

    logic             a_ok, b_ok, take_a;
    logic [VAL_W-1:0] w_win;
    logic             st_we, sc_we, done;
    t_idx             st_waddr;
    logic [VAL_W-1:0] st_wdata;

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_lo     = r_lo;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_cmp    = r_cmp;
        n_mov    = r_mov;
        done     = 1'b0;
        sc_we    = 1'b0;
        st_we    = 1'b0;
        st_waddr = i_wr_addr;
        st_wdata = i_wr_data;

        a_ok   = (r_a <= r_mid);
        b_ok   = (r_b <= r_hi);
        // left run wins ties, which keeps the sort stable
        take_a = a_ok && (!b_ok || ($signed(r_rd_a) <= $signed(r_rd_b)));
        w_win  = take_a ? r_rd_a : r_rd_b;

        unique case (r_state)
            MG_IDLE: begin
                st_we = i_wr_en;
                if (i_cmd.go) begin
                    n_lo    = i_cmd.lo;
                    n_mid   = i_cmd.mid;
                    n_hi    = i_cmd.hi;
                    n_a     = i_cmd.lo;
                    n_b     = i_cmd.mid + t_idx'(1);
                    n_k     = i_cmd.lo;
                    n_state = MG_MERGE;
                end else begin
                    // port a serves the result reads while idle
                    n_a = i_rd_addr;
                end
            end
            MG_MERGE: begin
                sc_we = 1'b1;
                if (take_a) begin
                    n_a = r_a + t_idx'(1);
                end else begin
                    n_b = r_b + t_idx'(1);
                end
                n_k = r_k + t_idx'(1);
                if (a_ok && b_ok) begin
                    n_cmp = r_cmp + CNT_W'(1);
                end
                n_mov = r_mov + CNT_W'(1);
                if (r_k == r_hi) begin
                    n_k     = r_lo;
                    n_state = MG_COPY;
                end
            end
            MG_COPY: begin
                st_we    = 1'b1;
                st_waddr = r_k;
                st_wdata = r_sc;
                n_k      = r_k + t_idx'(1);
                if (r_k == r_hi) begin
                    done    = 1'b1;
                    n_state = MG_IDLE;
                end
            end
            default: begin
                n_state = MG_IDLE;
            end
        endcase

        if (i_clr) begin
            n_cmp = '0;
            n_mov = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_store[n_a[AW-1:0]];
        r_rd_b <= r_store[n_b[AW-1:0]];
        r_sc   <= r_scratch[n_k[AW-1:0]];
        if (st_we) begin
            r_store[st_waddr[AW-1:0]] <= st_wdata;
        end
        if (sc_we) begin
            r_scratch[r_k[AW-1:0]] <= w_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_k   <= n_k;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MG_IDLE;
            r_cmp   <= '0;
            r_mov   <= '0;
        end else begin
            r_state <= n_state;
            r_cmp   <= n_cmp;
            r_mov   <= n_mov;
        end
    end

    assign o_rd_data   = r_rd_a;
    assign o_done      = done;
    assign o_cmp_total = r_cmp;
    assign o_mov_total = r_mov;

endmodule

/* rtl/mswc_seq.sv */
`timescale 1ns / 1ps

module mswc_seq #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  mswc_pkg::t_idx       i_hi,
    input  logic                 i_merge_done,
    output mswc_pkg::t_merge_cmd o_cmd,
    output logic                 o_done
);
    import mswc_pkg::*;

    localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SD  = AW + 1;
    localparam int FW  = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    t_frame         r_stk [SD];
    logic [SPW-1:0] r_sp, n_sp;
    t_seq_state     r_state, n_state;

    logic [SPW-1:0] w_topc;
    logic [FW-1:0]  w_top, w_push;
    t_frame         w_fr, push_fr;
    t_idx           w_mid;
    t_phase         upd_ph;
    logic           push_en, upd_en, pop_req, done;
    t_merge_cmd     cmd;

    assign w_topc = r_sp - SPW'(1);
    assign w_top  = w_topc[FW-1:0];
    assign w_push = r_sp[FW-1:0];
    assign w_fr   = r_stk[w_top];
    assign w_mid  = w_fr.lo + ((w_fr.hi - w_fr.lo) >> 1);

    always_comb begin
        n_state = r_state;
        n_sp    = r_sp;
        push_en = 1'b0;
        push_fr = '{lo: w_fr.lo, hi: w_mid, ph: PH_LEFT};
        upd_en  = 1'b0;
        upd_ph  = PH_RIGHT;
        pop_req = 1'b0;
        done    = 1'b0;
        cmd     = '{go: 1'b0, lo: w_fr.lo, mid: w_mid, hi: w_fr.hi};

        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    push_en = 1'b1;
                    push_fr = '{lo: '0, hi: i_hi, ph: PH_LEFT};
                    n_sp    = r_sp + SPW'(1);
                    n_state = SQ_STEP;
                end
            end
            SQ_STEP: begin
                case (w_fr.ph)
                    PH_LEFT: begin
                        if (w_fr.lo >= w_fr.hi) begin
                            pop_req = 1'b1;
                        end else begin
                            upd_en  = 1'b1;
                            upd_ph  = PH_RIGHT;
                            push_en = 1'b1;
                            push_fr = '{lo: w_fr.lo, hi: w_mid, ph: PH_LEFT};
                            n_sp    = r_sp + SPW'(1);
                        end
                    end
                    PH_RIGHT: begin
                        upd_en  = 1'b1;
                        upd_ph  = PH_MERGE;
                        push_en = 1'b1;
                        push_fr = '{lo: w_mid + t_idx'(1), hi: w_fr.hi, ph: PH_LEFT};
                        n_sp    = r_sp + SPW'(1);
                    end
                    PH_MERGE: begin
                        cmd.go  = 1'b1;
                        n_state = SQ_WAIT;
                    end
                    default: begin
                        pop_req = 1'b1;
                    end
                endcase
            end
            SQ_WAIT: begin
                pop_req = i_merge_done;
            end
            default: begin
                n_state = SQ_IDLE;
                n_sp    = '0;
            end
        endcase

        if (pop_req) begin
            n_sp = r_sp - SPW'(1);
            if (r_sp == SPW'(1)) begin
                done    = 1'b1;
                n_state = SQ_IDLE;
            end else begin
                n_state = SQ_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stk[w_push] <= push_fr;
        end
        if (upd_en) begin
            r_stk[w_top].ph <= upd_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
        end
    end

    assign o_cmd  = cmd;
    assign o_done = done;

endmodule

/* rtl/merge_sort_with_counts_unit.sv */
`timescale 1ns / 1ps
// loading: one item per cycle, busy stays low until the item marked last
// sorting: each merge of a run goes through the shared merge unit, merge steps into scratch
//   then copy-back steps into the store; the sequencer steps each split range through its
//   left, right and merge phases and pops each single-element range; busy high
// results: one per cycle once sorting ends, strobe registered; the receiver cannot stall
// synchronous active-low reset empties the set and clears both totals; stores are not cleared

module merge_sort_with_counts_unit #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic signed [31:0] i_element_value,
    input  logic               i_last_element,
    output logic               busy,
    output logic               o_strobe,
    output logic signed [31:0] o_sorted_value,
    output logic               o_last_result,
    output logic [8:0]         o_comparison_total,
    output logic [8:0]         o_move_total
);
    import mswc_pkg::*;

    t_top_state r_state, n_state;
    t_idx       r_count, n_count, r_idx, n_idx;
    logic       r_strobe, n_strobe, r_last, n_last;

    logic             accept, full, wr_en, seq_start, clr;
    t_idx             w_cnt, w_hi;
    t_merge_cmd       cmd;
    logic             merge_done, seq_done;
    logic [VAL_W-1:0] rd_data;
    logic [CNT_W-1:0] cmp_total, mov_total;

    assign accept = start && (r_state == TS_LOAD);
    assign full   = (r_count >= t_idx'(MAX_ELEMENTS));
    // an item beyond capacity is dropped, but a last one still starts the sort
    assign w_cnt  = full ? r_count : (r_count + t_idx'(1));
    assign w_hi   = w_cnt - t_idx'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_strobe  = 1'b0;
        n_last    = 1'b0;
        wr_en     = 1'b0;
        seq_start = 1'b0;
        clr       = 1'b0;

        unique case (r_state)
            TS_LOAD: begin
                if (accept) begin
                    wr_en   = !full;
                    n_count = w_cnt;
                    if (i_last_element) begin
                        seq_start = 1'b1;
                        clr       = 1'b1;
                        n_state   = TS_SORT;
                    end
                end
            end
            TS_SORT: begin
                if (seq_done) begin
                    n_idx   = '0;
                    n_state = TS_EMIT;
                end
            end
            TS_EMIT: begin
                n_idx    = r_idx + t_idx'(1);
                n_strobe = 1'b1;
                n_last   = (r_idx == (r_count - t_idx'(1)));
                if (n_last) begin
                    n_count = '0;
                    n_state = TS_LOAD;
                end
            end
            default: begin
                n_state = TS_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= TS_LOAD;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    mswc_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (seq_start),
        .i_hi         (w_hi),
        .i_merge_done (merge_done),
        .o_cmd        (cmd),
        .o_done       (seq_done)
    );

    mswc_merge #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_clr       (clr),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_count),
        .i_wr_data   (VAL_W'(unsigned'(i_element_value))),
        .i_rd_addr   (r_idx),
        .o_rd_data   (rd_data),
        .o_done      (merge_done),
        .o_cmp_total (cmp_total),
        .o_mov_total (mov_total)
    );

    assign busy               = (r_state != TS_LOAD);
    assign o_strobe           = r_strobe;
    assign o_sorted_value     = signed'(rd_data);
    assign o_last_result      = r_last;
    assign o_comparison_total = cmp_total;
    assign o_move_total       = mov_total;

endmodule

/* rtl/mswc_checker.sv */
`timescale 1ns / 1ps

module mswc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic signed [31:0] i_element_value,
    input logic               i_last_element,
    input logic               busy,
    input logic               o_strobe,
    input logic signed [31:0] o_sorted_value,
    input logic               o_last_result,
    input logic [8:0]         o_comparison_total,
    input logic [8:0]         o_move_total
);

    // results of a set come out back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_result |=> o_strobe)
        else $error("result burst broken before the last item");

    // the block frees up with the final result, and the burst ends there
    a_free_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_result |-> !busy ##1 !o_strobe)
        else $error("busy with the last result or strobe after it");

    // every merge step that compares also moves an element
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_move_total >= o_comparison_total)
        else $error("comparison total above move total");

    // totals hold over the whole burst
    a_totals_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_result |=>
            $stable(o_comparison_total) && $stable(o_move_total))
        else $error("totals changed within a result burst");

    // results only follow a busy period
    a_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a preceding sort");

endmodule

bind merge_sort_with_counts_unit mswc_checker u_mswc_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import mswc_pkg::*;

    localparam int MAX_ELEMENTS  = 64;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 85;
    localparam int QUIET_ITEMS   = 20;
    localparam int CYCLE_LIMIT   = 100000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic [8:0]         cmp;
        logic [8:0]         mov;
    } t_sorted;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               typed;
        logic [8:0]         cmp;
        logic [8:0]         mov;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic signed [31:0] i_element_value;
    logic               i_last_element;
    logic               busy;
    logic               o_strobe;
    logic signed [31:0] o_sorted_value;
    logic               o_last_result;
    logic [8:0]         o_comparison_total;
    logic [8:0]         o_move_total;

    // predictor state
    logic signed [31:0] held_values [MAX_ELEMENTS];
    logic signed [31:0] merge_copy [MAX_ELEMENTS];
    int                 held_count;
    logic [8:0]         cmp_count;
    logic [8:0]         mov_count;
    t_sorted            sorted_buf [MAX_ELEMENTS];

    t_sorted            pending_sorted[$];
    int                 failures;
    int                 cycle_count;

    merge_sort_with_counts_unit #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_element_value    (i_element_value),
        .i_last_element     (i_last_element),
        .busy               (busy),
        .o_strobe           (o_strobe),
        .o_sorted_value     (o_sorted_value),
        .o_last_result      (o_last_result),
        .o_comparison_total (o_comparison_total),
        .o_move_total       (o_move_total)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void merge_halves(int lo, int mid, int hi);
        int a;
        int b;
        int k;
        for (k = lo; k <= hi; k++) merge_copy[k] = held_values[k];
        a = lo;
        b = mid + 1;
        k = lo;
        while (a <= mid && b <= hi) begin
            // left side wins ties
            if (merge_copy[a] <= merge_copy[b]) begin
                held_values[k] = merge_copy[a];
                a++;
            end else begin
                held_values[k] = merge_copy[b];
                b++;
            end
            k++;
            cmp_count++;
            mov_count++;
        end
        while (a <= mid) begin
            held_values[k] = merge_copy[a];
            a++;
            k++;
            mov_count++;
        end
        while (b <= hi) begin
            held_values[k] = merge_copy[b];
            b++;
            k++;
            mov_count++;
        end
    endfunction

    // top-down recursion unrolled onto an explicit frame stack
    function automatic void sort_held(int n);
        int     fr_lo [16];
        int     fr_hi [16];
        t_phase fr_ph [16];
        int     sp;
        int     lo;
        int     hi;
        int     mid;
        sp = 1;
        fr_lo[0] = 0;
        fr_hi[0] = n - 1;
        fr_ph[0] = PH_LEFT;
        while (sp > 0) begin
            lo  = fr_lo[sp-1];
            hi  = fr_hi[sp-1];
            mid = lo + (hi - lo) / 2;
            if (lo >= hi) begin
                sp--;
            end else begin
                case (fr_ph[sp-1])
                    PH_LEFT: begin
                        fr_ph[sp-1] = PH_RIGHT;
                        fr_lo[sp] = lo;
                        fr_hi[sp] = mid;
                        fr_ph[sp] = PH_LEFT;
                        sp++;
                    end
                    PH_RIGHT: begin
                        fr_ph[sp-1] = PH_MERGE;
                        fr_lo[sp] = mid + 1;
                        fr_hi[sp] = hi;
                        fr_ph[sp] = PH_LEFT;
                        sp++;
                    end
                    default: begin
                        merge_halves(lo, mid, hi);
                        sp--;
                    end
                endcase
            end
        end
    endfunction

    // returns how many sorted values the item releases into sorted_buf
    function automatic int take_element(logic signed [31:0] v, logic l);
        int n;
        int k;
        if (held_count < MAX_ELEMENTS) begin
            held_values[held_count] = v;
            held_count++;
        end
        if (!l) return 0;
        n = held_count;
        cmp_count = '0;
        mov_count = '0;
        if (n > 1) sort_held(n);
        for (k = 0; k < n; k++) begin
            sorted_buf[k] = '{held_values[k], (k == n - 1), cmp_count, mov_count};
        end
        held_count = 0;
        return n;
    endfunction

    function automatic t_row dir_row(int i);
        case (i)
            0:  return '{32'sh8000_0000, 1'b1, 1'b1, 9'd0, 9'd0};
            1:  return '{32'sh7fff_ffff, 1'b1, 1'b1, 9'd0, 9'd0};
            2:  return '{32'sh0000_0000, 1'b1, 1'b1, 9'd0, 9'd0};
            3:  return '{32'shffff_ffff, 1'b1, 1'b1, 9'd0, 9'd0};
            4:  return '{32'sh7fff_ffff, 1'b0, 1'b0, 9'd0, 9'd0};
            5:  return '{32'sh8000_0000, 1'b1, 1'b0, 9'd0, 9'd0};
            6:  return '{32'sd5, 1'b0, 1'b0, 9'd0, 9'd0};
            7:  return '{32'sd5, 1'b0, 1'b0, 9'd0, 9'd0};
            8:  return '{-32'sd5, 1'b1, 1'b0, 9'd0, 9'd0};
            9:  return '{32'sd4, 1'b0, 1'b0, 9'd0, 9'd0};
            10: return '{32'sd3, 1'b0, 1'b0, 9'd0, 9'd0};
            11: return '{32'sd2, 1'b0, 1'b0, 9'd0, 9'd0};
            12: return '{32'sd1, 1'b1, 1'b0, 9'd0, 9'd0};
            13: return '{32'sh8000_0000, 1'b0, 1'b0, 9'd0, 9'd0};
            14: return '{-32'sd1, 1'b0, 1'b0, 9'd0, 9'd0};
            15: return '{32'sd0, 1'b0, 1'b0, 9'd0, 9'd0};
            16: return '{32'sd1, 1'b0, 1'b0, 9'd0, 9'd0};
            17: return '{32'sh7fff_ffff, 1'b1, 1'b0, 9'd0, 9'd0};
            18: return '{32'shaaaa_aaaa, 1'b0, 1'b0, 9'd0, 9'd0};
            19: return '{32'sh5555_5555, 1'b0, 1'b0, 9'd0, 9'd0};
            20: return '{32'sh8000_0001, 1'b0, 1'b0, 9'd0, 9'd0};
            21: return '{32'sh7fff_fffe, 1'b0, 1'b0, 9'd0, 9'd0};
            22: return '{-32'sd2, 1'b0, 1'b0, 9'd0, 9'd0};
            23: return '{32'sd5, 1'b0, 1'b0, 9'd0, 9'd0};
            default: return '{32'sd5, 1'b1, 1'b0, 9'd0, 9'd0};
        endcase
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            // narrow range so duplicates and ties are common
            2: return int'($urandom_range(0, 8)) - 4;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic int pick_gap(bit quiet);
        if (quiet || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 6);
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_element(input logic signed [31:0] v, input logic l, input int gap,
                                input bit use_typed, input t_sorted typed_exp);
        int n;
        int k;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start           <= 1'b1;
        i_element_value <= v;
        i_last_element  <= l;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n = take_element(v, l);
        if (use_typed) begin
            pending_sorted.push_back(typed_exp);
        end else begin
            for (k = 0; k < n; k++) pending_sorted.push_back(sorted_buf[k]);
        end
        @(negedge i_clk);
    endtask

    // start drops first so the held item is not taken again once busy clears
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_sorted.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp_v, got_v);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_sorted exp_item;
        if (i_rst_n && o_strobe) begin
            if (pending_sorted.size() == 0) begin
                $display("%0t unexpected result: expected none, got %0d",
                         $time, o_sorted_value);
                failures++;
            end else begin
                exp_item = pending_sorted.pop_front();
                check_field("sorted_value", exp_item.value, o_sorted_value);
                check_field("last_result", exp_item.last, o_last_result);
                check_field("comparison_total", exp_item.cmp, o_comparison_total);
                check_field("move_total", exp_item.mov, o_move_total);
            end
        end
    end

    initial begin : stimulus
        int   i;
        int   set_len;
        int   set_no;
        int   stored;
        t_row row;

        failures        = 0;
        cycle_count     = 0;
        held_count      = 0;
        cmp_count       = '0;
        mov_count       = '0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_element_value = '0;
        i_last_element  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            row = dir_row(i);
            send_element(row.value, row.last, pick_gap(1'b0), row.typed,
                         '{row.value, 1'b1, row.cmp, row.mov});
        end
        wait_drained();

        // one set overflows the store; the rest stay short
        set_no = 0;
        stored = 0;
        while (stored < RANDOM_ITEMS) begin
            set_len = (set_no == 3) ? $urandom_range(65, 67) : $urandom_range(1, 10);
            if (set_no == 3 || $urandom_range(0, 5) == 0) wait_drained();
            for (i = 0; i < set_len; i++) begin
                send_element(rand_value(), (i == set_len - 1),
                             pick_gap(stored >= RANDOM_ITEMS - QUIET_ITEMS), 1'b0, '0);
                if (i < MAX_ELEMENTS) stored++;
            end
            set_no++;
        end
        start <= 1'b0;

        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
